// ===== hw/rtl/vgc_pkg.sv =====
// Package for the greedy graph coloring block: sizes, codes, command and
// status types shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package vgc_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_DEGREE   = 16;

   localparam int VW        = $clog2(MAX_VERTICES);       // vertex index
   localparam int CNTW      = 11;                         // vertex_count field
   localparam int DEGW      = $clog2(MAX_DEGREE + 1);     // degree, holds MAX_DEGREE
   localparam int NCOLORS   = MAX_DEGREE + 1;
   localparam int COLW      = 5;                          // color field
   localparam int USEDW     = 5;                          // colors_used field
   localparam int RNDW      = 11;                         // rounds field
   localparam int STATW     = 2;
   localparam int OPW       = 2;
   localparam int ADJ_DEPTH = MAX_VERTICES * MAX_DEGREE;
   localparam int ADJ_AW    = $clog2(ADJ_DEPTH);
   localparam int ROUND_LIMIT = MAX_VERTICES + 1;
   localparam int ROUNDS_SAT  = 1024;
   localparam logic [CNTW-1:0] COUNT_RESET = CNTW'(1024);

   typedef enum logic [OPW-1:0] {
      OPC_CLEAR = 2'd0,
      OPC_EDGE  = 2'd1,
      OPC_RUN   = 2'd2,
      OPC_READ  = 2'd3
   } opcode_type;

   typedef enum logic [STATW-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_RANGE     = 2'd2,
      STAT_UNCOLORED = 2'd3
   } status_code_type;

   // datapath micro-operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_CLR,
      OP_E_CHK,
      OP_E_RDA,
      OP_E_RDB,
      OP_E_WRA,
      OP_E_WRB,
      OP_R_INIT,
      OP_R_START,
      OP_A_MARK,
      OP_A_MCHK,
      OP_A_ADJ,
      OP_A_COLRD,
      OP_A_COLUSE,
      OP_A_PICK,
      OP_B_MARK,
      OP_B_MCHK,
      OP_B_ADJ,
      OP_B_COLRD,
      OP_B_CMP,
      OP_B_WR,
      OP_R_END,
      OP_S_RD,
      OP_S_ACC,
      OP_S_END,
      OP_RD_CHK,
      OP_RD_USE,
      OP_RESP
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_CLR,
      ST_IDLE,
      ST_DISPATCH,
      ST_E_CHK,
      ST_E_RDA,
      ST_E_RDB,
      ST_E_WRA,
      ST_E_WRB,
      ST_R_INIT,
      ST_R_START,
      ST_A_MARK,
      ST_A_MCHK,
      ST_A_ADJ,
      ST_A_COLRD,
      ST_A_COLUSE,
      ST_A_PICK,
      ST_B_MARK,
      ST_B_MCHK,
      ST_B_ADJ,
      ST_B_COLRD,
      ST_B_CMP,
      ST_B_WR,
      ST_R_END,
      ST_S_RD,
      ST_S_ACC,
      ST_S_END,
      ST_RD_CHK,
      ST_RD_USE,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       edge_range;   // an endpoint not below the live count
      logic       self_loop;
      logic       deg_full;
      logic       mark_hit;     // conflict mark of the current vertex
      logic       k_done;       // adjacency list walked
      logic       v_last;       // last live vertex
      logic       v_last_all;   // last physical vertex
      logic       more_rounds;
      logic       read_range;
      logic       not_colored;
   } dp_status_type;

   // lowest color not in the forbidden mask
   function automatic logic [COLW-1:0] first_free(input logic [NCOLORS-1:0] mask);
      logic [COLW-1:0] pick;
      pick = '0;
      for (int i = NCOLORS - 1; i >= 0; i--) begin
         if (!mask[i]) pick = COLW'(i);
      end
      return pick;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vgc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vgc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/vgc_datapath.sv =====
// Datapath of the graph coloring block: graph memories, counters, result
// registers. Executes one micro-operation per cycle. Uses vgc_pkg, vgc_ram.
`default_nettype none

module vgc_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire vgc_pkg::dp_cmd_type      cmd,
   output vgc_pkg::dp_status_type        status,
   input  wire logic [1:0]               req_opcode,
   input  wire logic [9:0]               req_vertex_a,
   input  wire logic [9:0]               req_vertex_b,
   input  wire logic                     csr_valid,
   input  wire logic [10:0]              csr_vertex_count,
   output logic      [1:0]               rsp_status,
   output logic      [4:0]               rsp_color,
   output logic      [4:0]               rsp_colors_used,
   output logic      [10:0]              rsp_rounds
);
   import vgc_pkg::*;

   // control registers (reset)
   logic [CNTW-1:0] count_ff, count_in;
   logic            cv_ff, cv_in;
   logic [VW-1:0]   v_ff, v_in;

   // payload registers
   opcode_type        op_ff, op_in;
   logic [VW-1:0]     a_ff, a_in, b_ff, b_in, u_ff, u_in;
   logic [DEGW-1:0]   k_ff, k_in, deg_ff, deg_in, deg_a_ff, deg_a_in, deg_b_ff, deg_b_in;
   logic [NCOLORS-1:0] mask_ff, mask_in, seen_ff, seen_in;
   logic [COLW-1:0]   colv_ff, colv_in;
   logic              u_ok_ff, u_ok_in, own_ff, own_in, any_ff, any_in;
   logic [RNDW-1:0]   rounds_ff, rounds_in;
   status_code_type   res_status_ff, res_status_in;
   logic [COLW-1:0]   res_color_ff, res_color_in;
   logic [USEDW-1:0]  res_used_ff, res_used_in;
   logic [RNDW-1:0]   res_rounds_ff, res_rounds_in;
   logic [STATW-1:0]  rsp_status_ff, rsp_status_in;
   logic [COLW-1:0]   rsp_color_ff, rsp_color_in;
   logic [USEDW-1:0]  rsp_used_ff, rsp_used_in;
   logic [RNDW-1:0]   rsp_rounds_ff, rsp_rounds_in;

   // memory ports
   logic              deg_we, adj_we, col_we, mark_we;
   logic [VW-1:0]     deg_wa, deg_ra, col_wa, col_ra, mark_wa;
   logic [DEGW-1:0]   deg_wd, deg_rd;
   logic [ADJ_AW-1:0] adj_wa, adj_ra;
   logic [VW-1:0]     adj_wd, adj_rd;
   logic [COLW-1:0]   col_wd, col_rd;
   logic              mark_wd, mark_rd;

   logic [CNTW-1:0]   live;
   logic [VW-1:0]     n_last, v_next;
   logic              hit;
   logic [COLW-1:0]   pick;

   always_comb begin
      if (count_ff == '0) live = CNTW'(1);
      else if (count_ff > CNTW'(MAX_VERTICES)) live = CNTW'(MAX_VERTICES);
      else live = count_ff;
   end
   assign n_last = VW'(live - CNTW'(1));
   assign v_next = (v_ff == n_last) ? '0 : v_ff + VW'(1);
   assign hit    = u_ok_ff && (col_rd == colv_ff);
   assign pick   = first_free(mask_ff);

   always_comb begin
      status.opcode      = op_ff;
      status.edge_range  = ({1'b0, a_ff} >= live) || ({1'b0, b_ff} >= live);
      status.self_loop   = (a_ff == b_ff);
      status.deg_full    = (deg_a_ff >= DEGW'(MAX_DEGREE)) || (deg_b_ff >= DEGW'(MAX_DEGREE));
      status.mark_hit    = mark_rd;
      status.k_done      = (k_ff == deg_ff);
      status.v_last      = (v_ff == n_last);
      status.v_last_all  = (v_ff == VW'(MAX_VERTICES - 1));
      status.more_rounds = any_ff && (rounds_ff < RNDW'(ROUND_LIMIT));
      status.read_range  = ({1'b0, a_ff} >= live);
      status.not_colored = !cv_ff;
   end

   // memory addressing
   always_comb begin
      deg_we = 1'b0; deg_wa = v_ff; deg_wd = '0; deg_ra = v_ff;
      adj_we = 1'b0;
      adj_wa = ADJ_AW'(a_ff) * ADJ_AW'(MAX_DEGREE) + ADJ_AW'(deg_a_ff);
      adj_wd = b_ff;
      adj_ra = ADJ_AW'(v_ff) * ADJ_AW'(MAX_DEGREE) + ADJ_AW'(k_ff);
      col_we = 1'b0; col_wa = v_ff; col_wd = '0; col_ra = v_ff;
      mark_we = 1'b0; mark_wa = v_ff; mark_wd = 1'b0;
      case (cmd.op)
         OP_CLR: deg_we = 1'b1;
         OP_E_CHK: deg_ra = a_ff;
         OP_E_RDA: deg_ra = b_ff;
         OP_E_WRA: begin
            deg_we = !status.deg_full; deg_wa = a_ff; deg_wd = deg_a_ff + DEGW'(1);
            adj_we = !status.deg_full;
         end
         OP_E_WRB: begin
            deg_we = 1'b1; deg_wa = b_ff; deg_wd = deg_b_ff + DEGW'(1);
            adj_we = 1'b1;
            adj_wa = ADJ_AW'(b_ff) * ADJ_AW'(MAX_DEGREE) + ADJ_AW'(deg_b_ff);
            adj_wd = a_ff;
         end
         OP_R_INIT: begin
            col_we = 1'b1;
            mark_we = 1'b1; mark_wd = 1'b1;
         end
         OP_A_COLRD, OP_A_COLUSE, OP_B_COLRD, OP_B_CMP: col_ra = adj_rd;
         OP_A_PICK: begin
            col_we = 1'b1; col_wd = pick;
         end
         OP_B_WR: begin
            mark_we = 1'b1; mark_wd = own_ff;
         end
         OP_RD_CHK: col_ra = a_ff;
         default: ;
      endcase
      // an earlier vertex's mark is set by a conflict found from a later one
      if (cmd.op == OP_B_CMP && hit && (u_ff < v_ff)) begin
         mark_we = 1'b1; mark_wa = u_ff; mark_wd = 1'b1;
      end
   end

   // next state
   always_comb begin
      count_in = count_ff; cv_in = cv_ff; v_in = v_ff;
      op_in = op_ff; a_in = a_ff; b_in = b_ff; u_in = u_ff;
      k_in = k_ff; deg_in = deg_ff; deg_a_in = deg_a_ff; deg_b_in = deg_b_ff;
      mask_in = mask_ff; seen_in = seen_ff; colv_in = colv_ff;
      u_ok_in = u_ok_ff; own_in = own_ff; any_in = any_ff; rounds_in = rounds_ff;
      res_status_in = res_status_ff; res_color_in = res_color_ff;
      res_used_in = res_used_ff; res_rounds_in = res_rounds_ff;
      rsp_status_in = rsp_status_ff; rsp_color_in = rsp_color_ff;
      rsp_used_in = rsp_used_ff; rsp_rounds_in = rsp_rounds_ff;
      case (cmd.op)
         OP_LATCH: begin
            op_in = opcode_type'(req_opcode);
            a_in = req_vertex_a; b_in = req_vertex_b;
            v_in = '0;
            res_status_in = STAT_OK; res_color_in = '0;
            res_used_in = '0; res_rounds_in = '0;
         end
         OP_CLR: begin
            v_in = status.v_last_all ? '0 : v_ff + VW'(1);
            cv_in = 1'b0;
         end
         OP_E_CHK: if (status.edge_range) res_status_in = STAT_RANGE;
         OP_E_RDA: deg_a_in = deg_rd;
         OP_E_RDB: deg_b_in = deg_rd;
         OP_E_WRA: if (status.deg_full) res_status_in = STAT_FULL;
         OP_E_WRB: cv_in = 1'b0;
         OP_R_INIT: begin
            v_in = v_next; rounds_in = '0;
         end
         OP_R_START: begin
            rounds_in = rounds_ff + RNDW'(1); any_in = 1'b0;
         end
         OP_A_MCHK: begin
            if (mark_rd) begin
               deg_in = deg_rd; k_in = '0; mask_in = '0;
            end else v_in = v_next;
         end
         OP_A_COLRD: u_ok_in = ({1'b0, adj_rd} < live);
         OP_A_COLUSE: begin
            if (u_ok_ff) mask_in = mask_ff | (NCOLORS'(1) << col_rd);
            k_in = k_ff + DEGW'(1);
         end
         OP_A_PICK: v_in = v_next;
         OP_B_MCHK: begin
            if (mark_rd) begin
               deg_in = deg_rd; colv_in = col_rd; own_in = 1'b0; k_in = '0;
            end else v_in = v_next;
         end
         OP_B_COLRD: begin
            u_in = adj_rd; u_ok_in = ({1'b0, adj_rd} < live);
         end
         OP_B_CMP: begin
            if (hit) begin
               any_in = 1'b1;
               if (u_ff >= v_ff) own_in = 1'b1;
            end
            k_in = k_ff + DEGW'(1);
         end
         OP_B_WR: v_in = v_next;
         OP_R_END: begin
            seen_in = '0; res_used_in = '0;
         end
         OP_S_ACC: begin
            seen_in = seen_ff | (NCOLORS'(1) << col_rd);
            if (!seen_ff[col_rd]) res_used_in = res_used_ff + USEDW'(1);
            v_in = v_next;
         end
         OP_S_END: begin
            res_rounds_in = (rounds_ff > RNDW'(ROUNDS_SAT)) ? RNDW'(ROUNDS_SAT) : rounds_ff;
            cv_in = 1'b1;
         end
         OP_RD_CHK: begin
            if (status.read_range) res_status_in = STAT_RANGE;
            else if (!cv_ff) res_status_in = STAT_UNCOLORED;
         end
         OP_RD_USE: res_color_in = col_rd;
         OP_RESP: begin
            rsp_status_in = res_status_ff; rsp_color_in = res_color_ff;
            rsp_used_in = res_used_ff; rsp_rounds_in = res_rounds_ff;
         end
         default: ;
      endcase
      if (csr_valid) begin
         count_in = csr_vertex_count; cv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         cv_ff    <= 1'b0;
         v_ff     <= '0;
      end else begin
         count_ff <= count_in;
         cv_ff    <= cv_in;
         v_ff     <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; a_ff <= a_in; b_ff <= b_in; u_ff <= u_in;
      k_ff <= k_in; deg_ff <= deg_in; deg_a_ff <= deg_a_in; deg_b_ff <= deg_b_in;
      mask_ff <= mask_in; seen_ff <= seen_in; colv_ff <= colv_in;
      u_ok_ff <= u_ok_in; own_ff <= own_in; any_ff <= any_in; rounds_ff <= rounds_in;
      res_status_ff <= res_status_in; res_color_ff <= res_color_in;
      res_used_ff <= res_used_in; res_rounds_ff <= res_rounds_in;
      rsp_status_ff <= rsp_status_in; rsp_color_ff <= rsp_color_in;
      rsp_used_ff <= rsp_used_in; rsp_rounds_ff <= rsp_rounds_in;
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_color       = rsp_color_ff;
   assign rsp_colors_used = rsp_used_ff;
   assign rsp_rounds      = rsp_rounds_ff;

   vgc_ram #(.WIDTH(DEGW), .DEPTH(MAX_VERTICES)) u_deg_ram (
      .clock, .wr_en(deg_we), .wr_addr(deg_wa), .wr_data(deg_wd),
      .rd_addr(deg_ra), .rd_data(deg_rd));

   vgc_ram #(.WIDTH(VW), .DEPTH(ADJ_DEPTH)) u_adj_ram (
      .clock, .wr_en(adj_we), .wr_addr(adj_wa), .wr_data(adj_wd),
      .rd_addr(adj_ra), .rd_data(adj_rd));

   vgc_ram #(.WIDTH(COLW), .DEPTH(MAX_VERTICES)) u_col_ram (
      .clock, .wr_en(col_we), .wr_addr(col_wa), .wr_data(col_wd),
      .rd_addr(col_ra), .rd_data(col_rd));

   vgc_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_mark_ram (
      .clock, .wr_en(mark_we), .wr_addr(mark_wa), .wr_data(mark_wd),
      .rd_addr(v_ff), .rd_data(mark_rd));

   // picked color is never one a neighbor holds
   a_pick_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_A_PICK |-> !mask_ff[pick])
      else $error("picked color is forbidden");

   // list walk never passes the degree
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_A_ADJ || cmd.op == OP_B_ADJ) |-> k_ff <= deg_ff)
      else $error("adjacency index past degree");

   // round count bounded by the limit
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_R_END |-> rounds_ff <= RNDW'(ROUND_LIMIT))
      else $error("round limit exceeded");

endmodule

`default_nettype wire

// ===== hw/rtl/vgc_ctrl.sv =====
// Controller state machine of the graph coloring block: sequences the
// datapath micro-operations and owns the handshakes. Uses vgc_pkg.
`default_nettype none

module vgc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output vgc_pkg::dp_cmd_type        cmd,
   input  wire vgc_pkg::dp_status_type status
);
   import vgc_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           boot_ff, boot_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         boot_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      boot_in      = boot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      case (state_ff)
         ST_CLR: begin
            cmd.op = OP_CLR;
            if (status.v_last_all) begin
               state_in = boot_ff ? ST_IDLE : ST_DONE;
               boot_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.opcode)
               OPC_CLEAR: state_in = ST_CLR;
               OPC_EDGE:  state_in = ST_E_CHK;
               OPC_RUN:   state_in = ST_R_INIT;
               OPC_READ:  state_in = ST_RD_CHK;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_E_CHK: begin
            cmd.op   = OP_E_CHK;
            state_in = (status.edge_range || status.self_loop) ? ST_DONE : ST_E_RDA;
         end
         ST_E_RDA: begin
            cmd.op = OP_E_RDA; state_in = ST_E_RDB;
         end
         ST_E_RDB: begin
            cmd.op = OP_E_RDB; state_in = ST_E_WRA;
         end
         ST_E_WRA: begin
            cmd.op   = OP_E_WRA;
            state_in = status.deg_full ? ST_DONE : ST_E_WRB;
         end
         ST_E_WRB: begin
            cmd.op = OP_E_WRB; state_in = ST_DONE;
         end
         ST_R_INIT: begin
            cmd.op = OP_R_INIT;
            if (status.v_last) state_in = ST_R_START;
         end
         ST_R_START: begin
            cmd.op = OP_R_START; state_in = ST_A_MARK;
         end
         ST_A_MARK: begin
            cmd.op = OP_A_MARK; state_in = ST_A_MCHK;
         end
         ST_A_MCHK: begin
            cmd.op = OP_A_MCHK;
            if (status.mark_hit) state_in = ST_A_ADJ;
            else state_in = status.v_last ? ST_B_MARK : ST_A_MARK;
         end
         ST_A_ADJ: begin
            cmd.op   = OP_A_ADJ;
            state_in = status.k_done ? ST_A_PICK : ST_A_COLRD;
         end
         ST_A_COLRD: begin
            cmd.op = OP_A_COLRD; state_in = ST_A_COLUSE;
         end
         ST_A_COLUSE: begin
            cmd.op = OP_A_COLUSE; state_in = ST_A_ADJ;
         end
         ST_A_PICK: begin
            cmd.op   = OP_A_PICK;
            state_in = status.v_last ? ST_B_MARK : ST_A_MARK;
         end
         ST_B_MARK: begin
            cmd.op = OP_B_MARK; state_in = ST_B_MCHK;
         end
         ST_B_MCHK: begin
            cmd.op = OP_B_MCHK;
            if (status.mark_hit) state_in = ST_B_ADJ;
            else state_in = status.v_last ? ST_R_END : ST_B_MARK;
         end
         ST_B_ADJ: begin
            cmd.op   = OP_B_ADJ;
            state_in = status.k_done ? ST_B_WR : ST_B_COLRD;
         end
         ST_B_COLRD: begin
            cmd.op = OP_B_COLRD; state_in = ST_B_CMP;
         end
         ST_B_CMP: begin
            cmd.op = OP_B_CMP; state_in = ST_B_ADJ;
         end
         ST_B_WR: begin
            cmd.op   = OP_B_WR;
            state_in = status.v_last ? ST_R_END : ST_B_MARK;
         end
         ST_R_END: begin
            cmd.op   = OP_R_END;
            state_in = status.more_rounds ? ST_R_START : ST_S_RD;
         end
         ST_S_RD: begin
            cmd.op = OP_S_RD; state_in = ST_S_ACC;
         end
         ST_S_ACC: begin
            cmd.op   = OP_S_ACC;
            state_in = status.v_last ? ST_S_END : ST_S_RD;
         end
         ST_S_END: begin
            cmd.op = OP_S_END; state_in = ST_DONE;
         end
         ST_RD_CHK: begin
            cmd.op   = OP_RD_CHK;
            state_in = (status.read_range || status.not_colored) ? ST_DONE : ST_RD_USE;
         end
         ST_RD_USE: begin
            cmd.op = OP_RD_USE; state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_RESP;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   // a loaded result is always presented next cycle
   a_resp_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_RESP |=> rsp_valid_ff)
      else $error("result load lost");

   // one transaction in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while busy");

   // a waiting result stays up until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("result dropped before acceptance");

endmodule

`default_nettype wire

// ===== hw/rtl/vertex_greedy_graph_coloring.sv =====
// Each request (read, add edge, clear, run) steps through controller states; a run is
//   an init pass, then per round a pick pass and a conflict pass that work only on
//   conflict-marked vertices, then a color count pass, over the live vertices; the
//   steps follow from the single read port of each graph memory. One transaction at a
//   time; next request taken once the result is loaded into the response register.
// Reset: clearing pass over every entry of the degree memory, req_ready low.
// Top level of the greedy graph coloring block. Uses vgc_pkg, vgc_ctrl,
// vgc_datapath (which holds the vgc_ram instances).
`default_nettype none

module vertex_greedy_graph_coloring (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [9:0]  req_vertex_a,
   input  wire logic [9:0]  req_vertex_b,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_color,
   output logic [4:0]       rsp_colors_used,
   output logic [10:0]      rsp_rounds,
   // configuration: vertex_count
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [10:0] csr_vertex_count
);
   import vgc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Register writes land in the datapath directly and the port is always ready; the user
   // must write only while no transaction is in flight, as the block does not enforce it.
   assign csr_ready = 1'b1;

   // Controller: walks the run as nested passes (init, pick pass, conflict
   // pass, color count), using each memory port at most once per step, and owns the
   // request/response handshakes. The response register lets the next
   // request be taken while a result waits.
   vgc_ctrl u_ctrl (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .rsp_valid,
      .rsp_ready,
      .cmd,
      .status
   );

   // Datapath: adjacency, degree, color and conflict-mark memories plus the
   // vertex/neighbor counters, forbidden mask and result registers.
   vgc_datapath u_datapath (
      .clock,
      .reset,
      .cmd,
      .status,
      .req_opcode,
      .req_vertex_a,
      .req_vertex_b,
      .csr_valid(csr_valid && csr_ready),
      .csr_vertex_count,
      .rsp_status,
      .rsp_color,
      .rsp_colors_used,
      .rsp_rounds
   );

endmodule

`default_nettype wire

// ===== test/vertex_greedy_graph_coloring_tb.sv =====
// Self-checking testbench for vertex_greedy_graph_coloring: random and directed
// graph commands with a scoreboard class that predicts every response.
// Depends on vgc_pkg and the RTL top level only.
`default_nettype none

module vertex_greedy_graph_coloring_tb;
   import vgc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]  status;
      logic [4:0]  color;
      logic [4:0]  used;
      logic [10:0] rounds;
   } coloring_rsp_type;

   // Scoreboard: own copy of the graph, colors and vertex count.
   class coloring_scoreboard;
      logic [9:0]  adj_list[MAX_VERTICES][MAX_DEGREE];
      logic [4:0]  degree[MAX_VERTICES];
      logic [4:0]  vcolor[MAX_VERTICES];
      bit          mark[MAX_VERTICES];
      bit          is_colored;
      logic [10:0] vcount;
      coloring_rsp_type pending_rsp[$];
      int          errors;
      int          checked;

      function new();
         foreach (degree[i]) begin
            degree[i] = '0;
            vcolor[i] = '0;
            mark[i]   = 1'b0;
         end
         is_colored = 1'b0;
         vcount     = COUNT_RESET;
         errors     = 0;
         checked    = 0;
      endfunction

      function void set_count(logic [10:0] value);
         vcount     = value;
         is_colored = 1'b0;
      endfunction

      function int live_vertices();
         if (vcount == 0) return 1;
         if (vcount > MAX_VERTICES) return MAX_VERTICES;
         return vcount;
      endfunction

      // Conflict rounds of first-fit coloring; returns rounds, sets colors used.
      function int color_graph(int n, output int used);
         bit nxt[MAX_VERTICES];
         bit any;
         int rnd;
         logic [NCOLORS-1:0] forbid;
         logic [31:0] seen;
         int u;
         any = 1'b1;
         rnd = 0;
         for (int v = 0; v < n; v++) begin
            vcolor[v] = '0;
            mark[v]   = 1'b1;
         end
         while (any && rnd < ROUND_LIMIT) begin
            rnd++;
            for (int v = 0; v < n; v++) begin
               if (!mark[v]) continue;
               forbid = '0;
               for (int k = 0; k < degree[v]; k++) begin
                  u = adj_list[v][k];
                  if (u < n) forbid[vcolor[u]] = 1'b1;
               end
               vcolor[v] = '0;
               for (int c = NCOLORS - 1; c >= 0; c--)
                  if (!forbid[c]) vcolor[v] = 5'(c);
            end
            foreach (nxt[i]) nxt[i] = 1'b0;
            for (int v = 0; v < n; v++) begin
               if (!mark[v]) continue;
               for (int k = 0; k < degree[v]; k++) begin
                  u = adj_list[v][k];
                  if (u < n && vcolor[u] == vcolor[v]) nxt[(u < v) ? u : v] = 1'b1;
               end
            end
            any = 1'b0;
            for (int v = 0; v < n; v++) begin
               mark[v] = nxt[v];
               if (nxt[v]) any = 1'b1;
            end
         end
         seen = '0;
         for (int v = 0; v < n; v++) seen[vcolor[v]] = 1'b1;
         used = $countones(seen);
         return (rnd > ROUNDS_SAT) ? ROUNDS_SAT : rnd;
      endfunction

      // Accepted request transaction: update graph and queue the response.
      function void note_request(opcode_type op, logic [9:0] a, logic [9:0] b);
         coloring_rsp_type r;
         int n;
         int used;
         n = live_vertices();
         r.status = STAT_OK;
         r.color  = '0;
         r.used   = '0;
         r.rounds = '0;
         case (op)
            OPC_CLEAR: begin
               foreach (degree[i]) begin
                  degree[i] = '0;
                  vcolor[i] = '0;
                  mark[i]   = 1'b0;
               end
               is_colored = 1'b0;
            end
            OPC_EDGE: begin
               if (a >= n || b >= n) r.status = STAT_RANGE;
               else if (a != b) begin
                  if (degree[a] >= MAX_DEGREE || degree[b] >= MAX_DEGREE)
                     r.status = STAT_FULL;
                  else begin
                     adj_list[a][degree[a]] = b;
                     degree[a]++;
                     adj_list[b][degree[b]] = a;
                     degree[b]++;
                     is_colored = 1'b0;
                  end
               end
            end
            OPC_RUN: begin
               r.rounds   = 11'(color_graph(n, used));
               r.used     = 5'(used);
               is_colored = 1'b1;
            end
            default: begin
               if (a >= n) r.status = STAT_RANGE;
               else if (!is_colored) r.status = STAT_UNCOLORED;
               else r.color = vcolor[a];
            end
         endcase
         pending_rsp.push_back(r);
      endfunction

      function void check_response(logic [1:0] st, logic [4:0] col, logic [4:0] used,
                                   logic [10:0] rnd);
         coloring_rsp_type e;
         if (pending_rsp.size() == 0) begin
            $error("response transaction with nothing expected");
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         checked++;
         if (st !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, st);
            errors++;
         end
         if (col !== e.color) begin
            $error("color: expected %0d, actual %0d", e.color, col);
            errors++;
         end
         if (used !== e.used) begin
            $error("colors_used: expected %0d, actual %0d", e.used, used);
            errors++;
         end
         if (rnd !== e.rounds) begin
            $error("rounds: expected %0d, actual %0d", e.rounds, rnd);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_opcode;
   logic [9:0]  req_vertex_a, req_vertex_b;
   logic        rsp_valid, rsp_ready;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_color, rsp_colors_used;
   logic [10:0] rsp_rounds;
   logic        csr_valid, csr_ready;
   logic [10:0] csr_vertex_count;

   coloring_scoreboard sb;
   bit  steady_mode;    // no idling on either side while set
   bit  hold_off_req;   // receiver holds off for a long stretch
   int  sent_items;
   int  run_items;
   int  idle_cycles;

   vertex_greedy_graph_coloring u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_vertex_a    (req_vertex_a),
      .req_vertex_b    (req_vertex_b),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_color       (rsp_color),
      .rsp_colors_used (rsp_colors_used),
      .rsp_rounds      (rsp_rounds),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_vertex_count(csr_vertex_count)
   );

   always #10 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_mode || r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // One request transaction; valid stays up across back-to-back items.
   task automatic send_request(opcode_type op, logic [9:0] a, logic [9:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_vertex_a <= a;
      req_vertex_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, a, b);
      sent_items++;
      if (op == OPC_RUN) run_items++;
   endtask

   // sender pause: wait for every expected response
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);   // read latency margin
   endtask

   task automatic write_vertex_count(logic [10:0] value);
      drain_responses();
      csr_valid        <= 1'b1;
      csr_vertex_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_count(value);
      csr_valid <= 1'b0;
   endtask

   // Random mix: mostly in-range edges, runs and reads; a few clears and noise.
   task automatic random_phase(int count);
      int n, r;
      logic [9:0] a, b;
      n = sb.live_vertices();
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         a = 10'($urandom_range(0, n - 1));
         b = 10'($urandom_range(0, n - 1));
         if ($urandom_range(0, 9) == 0) a = 10'($urandom);
         if ($urandom_range(0, 9) == 0) b = 10'($urandom);
         if (r < 62)      send_request(OPC_EDGE, a, b);
         else if (r < 72) send_request(OPC_RUN, a, b);
         else if (r < 92) send_request(OPC_READ, a, b);
         else if (r < 94) send_request(OPC_CLEAR, a, b);
         else send_request(opcode_type'($urandom_range(0, 3)), 10'($urandom), 10'($urandom));
      end
   endtask

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_status, rsp_color, rsp_colors_used, rsp_rounds);
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold;
      bit rdy;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            hold = 0;
            while (hold < 400) begin
               @(posedge clock);
               hold++;
            end
            hold_off_req = 1'b0;
         end
         rdy = steady_mode || ($urandom_range(0, 99) < 70);
         if (!steady_mode && $urandom_range(0, 99) < 2) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end else begin
            rsp_ready <= rdy;
         end
      end
   end

   // watchdog: cycles with no transaction on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int counts[6];
      sb               = new();
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = '0;
      req_vertex_a     = '0;
      req_vertex_b     = '0;
      csr_valid        = 1'b0;
      csr_vertex_count = '0;
      steady_mode      = 1'b0;
      hold_off_req     = 1'b0;
      sent_items       = 0;
      run_items        = 0;
      idle_cycles      = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: small graph, every opcode and each corner case
      write_vertex_count(11'd8);
      send_request(OPC_READ, 10'd3, 10'd0);      // before any run
      send_request(OPC_READ, 10'd9, 10'd0);      // read out of range
      send_request(OPC_EDGE, 10'd9, 10'd1);      // endpoint out of range
      send_request(OPC_EDGE, 10'd1, 10'd8);
      send_request(OPC_EDGE, 10'd2, 10'd2);      // self loop
      send_request(OPC_RUN, 10'd0, 10'd0);       // empty graph
      send_request(OPC_READ, 10'd2, 10'd0);
      send_request(OPC_EDGE, 10'd0, 10'd1);
      send_request(OPC_EDGE, 10'd0, 10'd1);      // duplicate edge
      for (int i = 0; i < 14; i++)
         send_request(OPC_EDGE, 10'd0, 10'((i % 6) + 2));
      send_request(OPC_EDGE, 10'd3, 10'd0);      // list full
      send_request(OPC_RUN, 10'd0, 10'd0);
      send_request(OPC_READ, 10'd0, 10'd0);
      send_request(OPC_READ, 10'd7, 10'd0);
      send_request(OPC_CLEAR, 10'd0, 10'd0);
      send_request(OPC_READ, 10'd0, 10'd0);

      // random phases over several counts; 40 then 3 leaves stale neighbors
      counts = '{40, 3, 1024, 0, 2047, 1};
      for (int p = 0; p < 6; p++) begin
         write_vertex_count(11'(counts[p]));
         steady_mode = (p == 2);
         if (p == 1) hold_off_req = 1'b1;   // block fills and stalls its input
         random_phase(95);
         steady_mode = 1'b0;
      end
      write_vertex_count(11'($urandom_range(2, 64)));
      random_phase(30);

      drain_responses();
      repeat (50) @(posedge clock);
      $display("Covered %0d requests (%0d coloring runs), %0d responses checked,",
               sent_items, run_items, sb.checked);
      $display("vertex counts from 0 to 2047 and stale neighbors after shrink.");
      if (sb.errors == 0 && sb.pending_rsp.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
